@@ design/gemm_pkg.sv @@
// Package for the general matrix multiply block: word types of the request
// and response channels, request kind codes and register indexes.
// Used by general_matrix_multiply; depends on nothing else.
package gemm_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int ELEM_W      = 16;
   localparam int INDEX_W     = 4;
   localparam int DIM_W       = 5;

   typedef enum logic [1:0] {
      KIND_LOAD_A  = 2'd0,
      KIND_LOAD_B  = 2'd1,
      KIND_LOAD_C  = 2'd2,
      KIND_COMPUTE = 2'd3
   } gemm_kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DIM_M      = 3'd0,
      CSR_DIM_N      = 3'd1,
      CSR_DIM_K      = 3'd2,
      CSR_TRANS_A    = 3'd3,
      CSR_TRANS_B    = 3'd4,
      CSR_ALPHA_GAIN = 3'd5,
      CSR_BETA_GAIN  = 3'd6
   } gemm_csr_index_type;

   typedef struct packed {
      gemm_kind_type             req_type;
      logic [INDEX_W-1:0]        row_index;
      logic [INDEX_W-1:0]        col_index;
      logic signed [ELEM_W-1:0]  elem_value;
   } gemm_req_word_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0]  result_value;
      logic                      saturated;
   } gemm_rsp_word_type;

endpackage

@@ design/general_matrix_multiply.sv @@
// Top level of the general matrix multiply block: register file, sequencer,
// shared multiplier and the three matrix stores.
// Depends on gemm_pkg and gemm_ram.

// Load words write one element of A, B or C if both indexes are below MAX_DIM.
// A compute word returns C(row,col) = alpha*op(A)*op(B) + beta*C in Q8.8 and
// writes it back. dim_k is limited to MAX_DIM, and the one multiplier forms
// every product of the dot product and then the alpha and beta terms in turn.
// The response is held back while an earlier one still waits on rsp_stall,
// and the next word is taken in the first cycle the response is valid.
// Compute words outside dim_m by dim_n produce no response. The stores are
// not cleared after reset, so every element must be loaded before it is used.
module general_matrix_multiply #(
   parameter int MAX_DIM = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  gemm_pkg::gemm_req_word_type        req_word,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output gemm_pkg::gemm_rsp_word_type        rsp_word,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [gemm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [gemm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(MAX_DIM + 1);
   localparam int ACC_W  = 32 + $clog2(MAX_DIM);
   localparam int PROD_W = ACC_W + gemm_pkg::ELEM_W;
   localparam int TOT_W  = PROD_W + 1;
   localparam int Q_W    = TOT_W - 16;
   localparam int EW     = gemm_pkg::ELEM_W;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_DOT   = 7'b0000010,
      ST_DRAIN = 7'b0000100,
      ST_ALPHA = 7'b0001000,
      ST_BETA  = 7'b0010000,
      ST_SUM   = 7'b0100000,
      ST_FIN   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [gemm_pkg::DIM_W-1:0] dim_m_ff, dim_m_in;
   logic [gemm_pkg::DIM_W-1:0] dim_n_ff, dim_n_in;
   logic [gemm_pkg::DIM_W-1:0] dim_k_ff, dim_k_in;
   logic                       trans_a_ff, trans_a_in;
   logic                       trans_b_ff, trans_b_in;
   logic signed [EW-1:0]       alpha_ff, alpha_in;
   logic signed [EW-1:0]       beta_ff, beta_in;

   logic [CNT_W-1:0] eff_m, eff_n, eff_k;

   logic [gemm_pkg::INDEX_W-1:0] row_ff, row_in;
   logic [gemm_pkg::INDEX_W-1:0] col_ff, col_in;
   logic [ADDR_W-1:0]            caddr_ff, caddr_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         rd_vld_ff, rd_vld_in;
   logic                         prod_vld_ff, prod_vld_in;
   logic signed [ACC_W-1:0]      acc_ff, acc_in;
   logic signed [PROD_W-1:0]     prod_ff, prod_in;
   logic signed [TOT_W-1:0]      total_ff, total_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   gemm_pkg::gemm_rsp_word_type  rsp_word_ff, rsp_word_in;

   logic signed [ACC_W-1:0] mul_a;
   logic signed [EW-1:0]    mul_b;

   logic               req_accept, rsp_free, load_in_range, comp_in_range, issue;
   logic [ADDR_W-1:0]  req_addr, a_rd_addr, b_rd_addr;
   logic [EW-1:0]      a_rd_data, b_rd_data, c_rd_data;
   logic               a_wr_en, b_wr_en, c_wr_en;
   logic [ADDR_W-1:0]  c_wr_addr;
   logic [EW-1:0]      c_wr_data;
   logic signed [Q_W-1:0] q_val;
   logic               sat_hi, sat_lo;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign eff_m = (32'(dim_m_ff) > 32'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(dim_m_ff);
   assign eff_n = (32'(dim_n_ff) > 32'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(dim_n_ff);
   assign eff_k = (32'(dim_k_ff) > 32'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(dim_k_ff);

   assign load_in_range = (int'(req_word.row_index) < MAX_DIM)
                          && (int'(req_word.col_index) < MAX_DIM);
   assign comp_in_range = (int'(req_word.row_index) < int'(eff_m))
                          && (int'(req_word.col_index) < int'(eff_n));
   assign req_addr = ADDR_W'(int'(req_word.row_index) * MAX_DIM
                             + int'(req_word.col_index));

   assign issue = (state_ff == ST_DOT) && (cnt_ff < eff_k);

   assign a_rd_addr = trans_a_ff ? ADDR_W'(int'(cnt_ff) * MAX_DIM + int'(row_ff))
                                 : ADDR_W'(int'(row_ff) * MAX_DIM + int'(cnt_ff));
   assign b_rd_addr = trans_b_ff ? ADDR_W'(int'(col_ff) * MAX_DIM + int'(cnt_ff))
                                 : ADDR_W'(int'(cnt_ff) * MAX_DIM + int'(col_ff));

   assign a_wr_en = req_accept && load_in_range
                    && (req_word.req_type == gemm_pkg::KIND_LOAD_A);
   assign b_wr_en = req_accept && load_in_range
                    && (req_word.req_type == gemm_pkg::KIND_LOAD_B);

   assign q_val  = total_ff[TOT_W-1:16];
   assign sat_hi = !q_val[Q_W-1] && (|q_val[Q_W-2:15]);
   assign sat_lo = q_val[Q_W-1] && !(&q_val[Q_W-2:15]);

   always_comb begin
      dim_m_in   = dim_m_ff;
      dim_n_in   = dim_n_ff;
      dim_k_in   = dim_k_ff;
      trans_a_in = trans_a_ff;
      trans_b_in = trans_b_ff;
      alpha_in   = alpha_ff;
      beta_in    = beta_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            gemm_pkg::CSR_DIM_M:      dim_m_in   = csr_wdata[gemm_pkg::DIM_W-1:0];
            gemm_pkg::CSR_DIM_N:      dim_n_in   = csr_wdata[gemm_pkg::DIM_W-1:0];
            gemm_pkg::CSR_DIM_K:      dim_k_in   = csr_wdata[gemm_pkg::DIM_W-1:0];
            gemm_pkg::CSR_TRANS_A:    trans_a_in = csr_wdata[0];
            gemm_pkg::CSR_TRANS_B:    trans_b_in = csr_wdata[0];
            gemm_pkg::CSR_ALPHA_GAIN: alpha_in   = signed'(csr_wdata[EW-1:0]);
            gemm_pkg::CSR_BETA_GAIN:  beta_in    = signed'(csr_wdata[EW-1:0]);
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      caddr_in     = caddr_ff;
      cnt_in       = cnt_ff;
      rd_vld_in    = issue;
      prod_vld_in  = rd_vld_ff;
      acc_in       = prod_vld_ff ? acc_ff + ACC_W'(prod_ff) : acc_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      mul_a        = ACC_W'(signed'(a_rd_data));
      mul_b        = signed'(b_rd_data);
      c_wr_en      = req_accept && load_in_range
                     && (req_word.req_type == gemm_pkg::KIND_LOAD_C);
      c_wr_addr    = req_addr;
      c_wr_data    = req_word.elem_value;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_word.req_type == gemm_pkg::KIND_COMPUTE)
                && comp_in_range) begin
               row_in   = req_word.row_index;
               col_in   = req_word.col_index;
               caddr_in = req_addr;
               cnt_in   = '0;
               acc_in   = '0;
               state_in = ST_DOT;
            end
         end
         ST_DOT: begin
            if (issue) begin
               cnt_in = cnt_ff + 1'b1;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !prod_vld_ff) begin
               state_in = ST_ALPHA;
            end
         end
         ST_ALPHA: begin
            mul_a    = acc_ff;
            mul_b    = alpha_ff;
            state_in = ST_BETA;
         end
         ST_BETA: begin
            mul_a    = ACC_W'(signed'(c_rd_data));
            mul_b    = beta_ff;
            total_in = TOT_W'(prod_ff);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (beta_ff != '0) begin
               total_in = total_ff + (TOT_W'(prod_ff) <<< 8);
            end
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (rsp_free) begin
               rsp_valid_in             = 1'b1;
               rsp_word_in.saturated    = sat_hi || sat_lo;
               rsp_word_in.result_value = sat_hi ? 16'sh7FFF
                                        : sat_lo ? 16'sh8000
                                        : q_val[EW-1:0];
               c_wr_en   = 1'b1;
               c_wr_addr = caddr_ff;
               c_wr_data = rsp_word_in.result_value;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dim_m_ff     <= gemm_pkg::DIM_W'(16);
         dim_n_ff     <= gemm_pkg::DIM_W'(16);
         dim_k_ff     <= gemm_pkg::DIM_W'(16);
         trans_a_ff   <= 1'b0;
         trans_b_ff   <= 1'b0;
         alpha_ff     <= 16'sd256;
         beta_ff      <= '0;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dim_m_ff     <= dim_m_in;
         dim_n_ff     <= dim_n_in;
         dim_k_ff     <= dim_k_in;
         trans_a_ff   <= trans_a_in;
         trans_b_ff   <= trans_b_in;
         alpha_ff     <= alpha_in;
         beta_ff      <= beta_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         prod_vld_ff  <= prod_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      col_ff      <= col_in;
      caddr_ff    <= caddr_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      total_ff    <= total_in;
      rsp_word_ff <= rsp_word_in;
   end

   gemm_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_a_store (
      .clock      (clock),
      .wr_en      (a_wr_en),
      .wr_addr    (req_addr),
      .wr_data    (req_word.elem_value),
      .rd_en      (issue),
      .rd_addr    (a_rd_addr),
      .rd_data_ff (a_rd_data)
   );

   gemm_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_b_store (
      .clock      (clock),
      .wr_en      (b_wr_en),
      .wr_addr    (req_addr),
      .wr_data    (req_word.elem_value),
      .rd_en      (issue),
      .rd_addr    (b_rd_addr),
      .rd_data_ff (b_rd_data)
   );

   gemm_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_c_store (
      .clock      (clock),
      .wr_en      (c_wr_en),
      .wr_addr    (c_wr_addr),
      .wr_data    (c_wr_data),
      .rd_en      (1'b1),
      .rd_addr    (caddr_ff),
      .rd_data_ff (c_rd_data)
   );

endmodule

@@ design/gemm_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the matrix stores of general_matrix_multiply; no dependencies.
module gemm_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule
